### rtl/core/vsm_pkg.sv
// ----------------------------------------------------------------------------
// vsm_pkg
// Types and constants shared by the vCPU slice monitor and its cells.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package vsm_pkg;

   typedef struct packed {
      logic [3:0]  vcpu_index;
      logic [31:0] elapsed_ns;
   } req_type;

   typedef struct packed {
      logic [3:0]  sample_vcpu;
      logic        sample_used;
      logic        alive;
      logic [47:0] remaining_ns;
      logic        io_moved;
      logic [3:0]  io_location;
   } rsp_type;

   localparam int unsigned CSR_IDX_W = 2;
   localparam int unsigned CSR_DATA_W = 32;

   localparam logic [CSR_IDX_W-1:0] CSR_STALE_LIMIT = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_RUN_THRESHOLD = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_ESCAPE_MARGIN = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_IO_HOME = 2'd3;

   localparam logic [31:0] STALE_LIMIT_RESET = 32'd50000000;
   localparam logic [31:0] RUN_THRESHOLD_RESET = 32'd200000;
   localparam logic [31:0] ESCAPE_MARGIN_RESET = 32'd700000;
   localparam logic [3:0] IO_HOME_RESET = 4'd0;

   typedef enum logic [6:0] {
      ST_IDLE = 7'b0000001,
      ST_ACC  = 7'b0000010,
      ST_SUB  = 7'b0000100,
      ST_DEC  = 7'b0001000,
      ST_SCAN = 7'b0010000,
      ST_MOVE = 7'b0100000,
      ST_RESP = 7'b1000000
   } state_type;

   typedef enum logic [1:0] {
      CELL_HOLD = 2'd0,
      CELL_ACC  = 2'd1,
      CELL_DEC  = 2'd2
   } cell_op_type;

   typedef struct packed {
      cell_op_type op;
      logic        is_run;
      logic [3:0]  vcpu;
   } cell_cmd_type;

   typedef struct packed {
      logic alive;
      logic low;
   } cell_stat_type;

endpackage

### rtl/core/vsm_cell.sv
// ----------------------------------------------------------------------------
// vsm_cell
// Per-vCPU cell: run accumulator, slice estimate, remaining time and alive
// mark, plus one stage of the maximum-remaining-time search chain.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module vsm_cell #(
   parameter int TIME_WIDTH = 48,
   parameter int HOLD_W = 4,
   parameter int INDEX = 0
) (
   input  logic                      clock,
   input  logic                      reset,
   input  vsm_pkg::cell_cmd_type     cmd_in,
   input  logic [31:0]               elapsed_in,
   input  logic [31:0]               margin_in,
   input  logic [TIME_WIDTH-1:0]     best_in,
   input  logic [HOLD_W-1:0]         idx_in,
   output logic [TIME_WIDTH-1:0]     best_out,
   output logic [HOLD_W-1:0]         idx_out,
   output vsm_pkg::cell_stat_type    stat_out,
   output logic [TIME_WIDTH-1:0]     rem_out
);
   import vsm_pkg::*;

   logic [TIME_WIDTH-1:0] acc_ff;
   logic [TIME_WIDTH-1:0] est_ff;
   logic [TIME_WIDTH-1:0] rem_ff;
   logic                  alive_ff;
   logic [TIME_WIDTH:0]   diff_ff;
   logic [TIME_WIDTH:0]   diff_in;
   logic [TIME_WIDTH:0]   sum_in;
   logic [TIME_WIDTH-1:0] best_ff;
   logic [HOLD_W-1:0]     idx_ff;
   logic                  sel;
   logic                  low;
   logic                  take;

   assign sel = (HOLD_W'(cmd_in.vcpu) == HOLD_W'(INDEX));
   assign sum_in = {1'b0, acc_ff} + (TIME_WIDTH + 1)'(elapsed_in);
   assign diff_in = {1'b0, est_ff} - {1'b0, acc_ff};
   assign low = diff_ff[TIME_WIDTH]
                || (diff_ff[TIME_WIDTH-1:0] < TIME_WIDTH'(margin_in));
   assign take = (rem_ff >= best_in);

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff <= '0;
         est_ff <= '0;
         rem_ff <= '0;
         alive_ff <= 1'b0;
      end else begin
         case (cmd_in.op)
            CELL_ACC: begin
               if (sel) begin
                  if (cmd_in.is_run) begin
                     acc_ff <= sum_in[TIME_WIDTH] ? '1 : sum_in[TIME_WIDTH-1:0];
                  end else begin
                     est_ff <= acc_ff;
                     acc_ff <= '0;
                  end
               end
            end
            CELL_DEC: begin
               if (sel) begin
                  alive_ff <= !low;
                  if (low) begin
                     rem_ff <= diff_ff[TIME_WIDTH] ? '0 : diff_ff[TIME_WIDTH-1:0];
                  end else if (diff_ff[TIME_WIDTH-1:0] != '0) begin
                     rem_ff <= diff_ff[TIME_WIDTH-1:0];
                  end
               end
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      diff_ff <= diff_in;
      best_ff <= take ? rem_ff : best_in;
      idx_ff <= take ? HOLD_W'(INDEX) : idx_in;
   end

   assign best_out = best_ff;
   assign idx_out = idx_ff;
   assign stat_out.alive = alive_ff;
   assign stat_out.low = low;
   assign rem_out = rem_ff;

endmodule

### rtl/core/vcpu_slice_monitor_migrator.sv
// ----------------------------------------------------------------------------
// vcpu_slice_monitor_migrator
// Tracks the scheduler time slice of each vCPU from timing samples and moves
// the IO thread away from a vCPU that is about to be descheduled. Each vCPU
// has its own cell; the cells form a chain that carries the running maximum
// of remaining time one cell per cycle. The block handles one item at a
// time. A stale or out-of-range sample gives its result in the cycle after
// acceptance; an applied sample passes through the ACC, SUB and DEC states
// first, and a sample that drives the IO thread holder below the escape
// margin also through SCAN, while the search walks the cell chain, and MOVE.
// A new item is taken in the cycle after its result has been taken.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module vcpu_slice_monitor_migrator #(
   parameter int NUM_VCPU = 12,
   parameter int TIME_WIDTH = 48
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  vsm_pkg::req_type                    req_data,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output vsm_pkg::rsp_type                    rsp_data,
   input  logic                                csr_we,
   input  logic [vsm_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [vsm_pkg::CSR_DATA_W-1:0]      csr_wdata
);
   import vsm_pkg::*;

   localparam int HOLD_W = (NUM_VCPU > 16) ? $clog2(NUM_VCPU) : 4;
   localparam int CNT_W = $clog2(NUM_VCPU);

   state_type             state_ff;
   state_type             state_in;
   logic [31:0]           stale_ff;
   logic [31:0]           thresh_ff;
   logic [31:0]           margin_ff;
   logic [HOLD_W-1:0]     holder_ff;
   logic [3:0]            vcpu_ff;
   logic [31:0]           elapsed_ff;
   logic                  in_range_ff;
   logic                  used_ff;
   logic                  run_ff;
   logic                  moved_ff;
   logic [CNT_W-1:0]      cnt_ff;
   logic                  accept;
   logic                  in_range_in;
   cell_cmd_type          cmd;
   logic [TIME_WIDTH-1:0] tok_best [NUM_VCPU+1];
   logic [HOLD_W-1:0]     tok_idx [NUM_VCPU+1];
   cell_stat_type         stat [NUM_VCPU];
   logic [TIME_WIDTH-1:0] rem [NUM_VCPU];
   logic                  alive_sel;
   logic                  low_sel;
   logic [TIME_WIDTH-1:0] rem_sel;
   logic                  holder_hit;

   assign accept = req_valid && req_ready;
   assign req_ready = (state_ff == ST_IDLE);
   assign in_range_in = {28'd0, req_data.vcpu_index} < 32'(NUM_VCPU);
   assign holder_hit = (holder_ff == HOLD_W'(vcpu_ff));

   always_comb begin
      cmd.vcpu = vcpu_ff;
      cmd.is_run = run_ff;
      case (state_ff)
         ST_ACC: cmd.op = CELL_ACC;
         ST_DEC: cmd.op = CELL_DEC;
         default: cmd.op = CELL_HOLD;
      endcase
   end

   assign tok_best[0] = '0;
   assign tok_idx[0] = '0;

   for (genvar gi = 0; gi < NUM_VCPU; gi++) begin : g_cell
      vsm_cell #(
         .TIME_WIDTH(TIME_WIDTH),
         .HOLD_W(HOLD_W),
         .INDEX(gi)
      ) u_cell (
         .clock(clock),
         .reset(reset),
         .cmd_in(cmd),
         .elapsed_in(elapsed_ff),
         .margin_in(margin_ff),
         .best_in(tok_best[gi]),
         .idx_in(tok_idx[gi]),
         .best_out(tok_best[gi+1]),
         .idx_out(tok_idx[gi+1]),
         .stat_out(stat[gi]),
         .rem_out(rem[gi])
      );
   end

   always_comb begin
      alive_sel = 1'b0;
      low_sel = 1'b0;
      rem_sel = '0;
      for (int i = 0; i < NUM_VCPU; i++) begin
         if (HOLD_W'(vcpu_ff) == HOLD_W'(i)) begin
            alive_sel = alive_sel | stat[i].alive;
            low_sel = low_sel | stat[i].low;
            rem_sel = rem_sel | rem[i];
         end
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (in_range_in && (req_data.elapsed_ns <= stale_ff)) begin
                  state_in = ST_ACC;
               end else begin
                  state_in = ST_RESP;
               end
            end
         end
         ST_ACC: state_in = ST_SUB;
         ST_SUB: state_in = ST_DEC;
         ST_DEC: state_in = (low_sel && holder_hit) ? ST_SCAN : ST_RESP;
         ST_SCAN: begin
            if (cnt_ff == CNT_W'(NUM_VCPU - 1)) begin
               state_in = ST_MOVE;
            end
         end
         ST_MOVE: state_in = ST_RESP;
         ST_RESP: begin
            if (rsp_ready) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         stale_ff <= STALE_LIMIT_RESET;
         thresh_ff <= RUN_THRESHOLD_RESET;
         margin_ff <= ESCAPE_MARGIN_RESET;
         holder_ff <= HOLD_W'(IO_HOME_RESET);
         moved_ff <= 1'b0;
         used_ff <= 1'b0;
         in_range_ff <= 1'b0;
         cnt_ff <= '0;
      end else begin
         state_ff <= state_in;
         if (csr_we) begin
            case (csr_index)
               CSR_STALE_LIMIT: stale_ff <= csr_wdata;
               CSR_RUN_THRESHOLD: thresh_ff <= csr_wdata;
               CSR_ESCAPE_MARGIN: margin_ff <= csr_wdata;
               CSR_IO_HOME: holder_ff <= HOLD_W'(csr_wdata[3:0]);
               default: begin
               end
            endcase
         end
         if (accept) begin
            moved_ff <= 1'b0;
            in_range_ff <= in_range_in;
            used_ff <= in_range_in && (req_data.elapsed_ns <= stale_ff);
         end
         if (state_ff == ST_SCAN) begin
            cnt_ff <= cnt_ff + CNT_W'(1);
         end else begin
            cnt_ff <= '0;
         end
         if ((state_ff == ST_MOVE) && (tok_idx[NUM_VCPU] != HOLD_W'(vcpu_ff))) begin
            holder_ff <= tok_idx[NUM_VCPU];
            moved_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         vcpu_ff <= req_data.vcpu_index;
         elapsed_ff <= req_data.elapsed_ns;
         run_ff <= req_data.elapsed_ns < thresh_ff;
      end
   end

   assign rsp_valid = (state_ff == ST_RESP);
   assign rsp_data.sample_vcpu = vcpu_ff;
   assign rsp_data.sample_used = used_ff;
   assign rsp_data.alive = in_range_ff && alive_sel;
   assign rsp_data.remaining_ns = in_range_ff ? 48'(rem_sel) : 48'd0;
   assign rsp_data.io_moved = moved_ff;
   assign rsp_data.io_location = holder_ff[3:0];

`ifndef SYNTH
   a_accept_next: assert property (@(posedge clock) disable iff (reset)
      accept |=> (state_ff == ST_ACC) || (state_ff == ST_RESP))
      else $error("accepted item did not start processing");

   a_move_needs_use: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.io_moved |-> rsp_data.sample_used && !rsp_data.alive)
      else $error("IO thread moved on a sample that did not escape");

   a_move_leaves: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.io_moved |-> !holder_hit)
      else $error("IO thread moved onto the escaping vCPU");

   a_unused_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !in_range_ff |-> !rsp_data.alive && (rsp_data.remaining_ns == 48'd0))
      else $error("out-of-range item reported vCPU state");

   a_scan_count: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCAN) |-> ({1'b0, cnt_ff} < (CNT_W + 1)'(NUM_VCPU)))
      else $error("search counter ran past the cell chain");
`endif

endmodule
